@@ rtl/core/gdfts_pkg.sv @@
// Shared codes and controller/datapath interface types for the grid search block.
package gdfts_pkg;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_START   = 2'd1;
   localparam logic [1:0] KIND_ADVANCE = 2'd2;

   localparam logic [1:0] EV_START  = 2'd0;
   localparam logic [1:0] EV_STEP   = 2'd1;
   localparam logic [1:0] EV_BACK   = 2'd2;
   localparam logic [1:0] EV_FINISH = 2'd3;

   localparam logic [1:0] CODE_NOT     = 2'd0;
   localparam logic [1:0] CODE_FOUND   = 2'd1;
   localparam logic [1:0] CODE_INVALID = 2'd2;

   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_EAST  = 2'd1;
   localparam logic [1:0] DIR_SOUTH = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic       latch;
      logic       load_cell;
      logic       clr_init;
      logic       clr_step;
      logic       rd_start;
      logic       rd_nbr;
      logic       enter;
      logic       start_init;
      logic       push;
      logic       fail;
      logic       path;
      logic       pop_load;
      logic       emit;
      logic [1:0] ev;
      logic [1:0] code;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       clr_last;
      logic       in_ok;
      logic       exists;
      logic       target;
      logic       visited;
      logic       dir_last;
      logic       depth_one;
      logic       depth_zero;
      logic       depth_full;
      logic       rsp_busy;
   } dp_sts_type;

endpackage

@@ rtl/core/gdfts_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module gdfts_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/gdfts_dp.sv @@
// Datapath: grid maps, search stack, walker, config registers and response register.
module gdfts_dp import gdfts_pkg::*; #(
   parameter int MAX_WIDTH  = 16,
   parameter int MAX_HEIGHT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   input  logic [1:0]  req_tuser,
   input  logic [15:0] req_tdata,
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [4:0]  csr_wdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int DW    = $clog2(CELLS + 1);
   localparam int SW    = CW + RW + 2;
   localparam int WXW   = (CW > 4) ? CW : 4;
   localparam int WYW   = (RW > 4) ? RW : 4;

   logic [4:0]    width_ff, height_ff;
   logic [3:0]    rx_ff, ry_ff;
   logic [CW-1:0] top_x_ff, pend_x_ff;
   logic [RW-1:0] top_y_ff, pend_y_ff;
   logic [1:0]    top_dir_ff;
   logic [DW-1:0] depth_ff;
   logic [WXW-1:0] walker_x_ff;
   logic [WYW-1:0] walker_y_ff;
   logic [AW-1:0] clr_cnt_ff, pend_idx_ff;
   logic          pend_ok_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   logic [1:0]    rsp_ev_ff, rsp_dir_ff, rsp_code_ff;
   logic [3:0]    rsp_x_ff, rsp_y_ff;

   logic [6:0]    effw, effh, nx, ny, sx, sy, rd_x, rd_y;
   logic          nbr_ok, rd_ok;
   logic [AW-1:0] rd_idx, ld_idx;
   logic          ld_in_range;
   logic [1:0]    cell_q;
   logic          vis_q;
   logic [SW-1:0] stack_q;
   logic          vis_we;
   logic [AW-1:0] vis_waddr;
   logic [3:0]    in_x, in_y;

   assign in_x = req_tdata[3:0];
   assign in_y = req_tdata[7:4];

   assign effw = ({2'b0, width_ff} > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : {2'b0, width_ff};
   assign effh = ({2'b0, height_ff} > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : {2'b0, height_ff};

   // Neighbor of the top of stack in the direction it is trying next.
   always_comb begin
      nx = 7'(top_x_ff);
      ny = 7'(top_y_ff);
      nbr_ok = 1'b1;
      unique case (top_dir_ff)
         DIR_NORTH: begin
            ny = 7'(top_y_ff) - 7'd1;
            nbr_ok = (top_y_ff != '0);
         end
         DIR_EAST:  nx = 7'(top_x_ff) + 7'd1;
         DIR_SOUTH: ny = 7'(top_y_ff) + 7'd1;
         default: begin
            nx = 7'(top_x_ff) - 7'd1;
            nbr_ok = (top_x_ff != '0);
         end
      endcase
   end

   assign sx     = {3'b0, rx_ff};
   assign sy     = {3'b0, ry_ff};
   assign rd_x   = cmd.rd_start ? sx : nx;
   assign rd_y   = cmd.rd_start ? sy : ny;
   assign rd_ok  = (cmd.rd_start || nbr_ok) && (rd_x < effw) && (rd_y < effh);
   assign rd_idx = AW'(32'(rd_y) * MAX_WIDTH + 32'(rd_x));

   assign ld_in_range = (32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT);
   assign ld_idx      = AW'(32'(in_y) * MAX_WIDTH + 32'(in_x));

   gdfts_ram #(.WIDTH(2), .DEPTH(CELLS)) u_cell_ram (
      .clock (clock),
      .we    (cmd.load_cell && ld_in_range),
      .waddr (ld_idx),
      .wdata (req_tdata[9:8]),
      .raddr (rd_idx),
      .rdata (cell_q)
   );

   assign vis_we    = cmd.clr_step || cmd.enter;
   assign vis_waddr = cmd.clr_step ? clr_cnt_ff : pend_idx_ff;

   gdfts_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited_ram (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (cmd.enter),
      .raddr (rd_idx),
      .rdata (vis_q)
   );

   // The top entry lives in registers; the RAM holds the entries below it.
   gdfts_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack_ram (
      .clock (clock),
      .we    (cmd.push),
      .waddr (AW'(depth_ff - DW'(1))),
      .wdata ({top_x_ff, top_y_ff, top_dir_ff}),
      .raddr (AW'(depth_ff - DW'(2))),
      .rdata (stack_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= 5'd16;
         height_ff    <= 5'd16;
         depth_ff     <= '0;
         walker_x_ff  <= '0;
         walker_y_ff  <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            if (csr_addr == REG_WIDTH) begin
               width_ff <= csr_wdata;
            end else begin
               height_ff <= csr_wdata;
            end
         end
         if (cmd.clr_init) begin
            clr_cnt_ff <= '0;
            depth_ff   <= '0;
         end
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (cmd.rd_start) begin
            walker_x_ff <= WXW'(rx_ff);
            walker_y_ff <= WYW'(ry_ff);
         end
         if (cmd.enter) begin
            walker_x_ff <= WXW'(pend_x_ff);
            walker_y_ff <= WYW'(pend_y_ff);
         end
         if (cmd.start_init) begin
            depth_ff <= DW'(1);
         end
         if (cmd.push) begin
            depth_ff <= depth_ff + DW'(1);
         end
         // A failed direction puts the walker back on the cell that tried it.
         if (cmd.fail) begin
            walker_x_ff <= WXW'(top_x_ff);
            walker_y_ff <= WYW'(top_y_ff);
            if (top_dir_ff == DIR_WEST) begin
               depth_ff <= depth_ff - DW'(1);
            end
         end
         if (cmd.path) begin
            depth_ff <= depth_ff - DW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rx_ff <= in_x;
         ry_ff <= in_y;
      end
      if (cmd.rd_start || cmd.rd_nbr) begin
         pend_idx_ff <= rd_idx;
         pend_ok_ff  <= rd_ok;
         pend_x_ff   <= CW'(rd_x);
         pend_y_ff   <= RW'(rd_y);
      end
      if (cmd.start_init || cmd.push) begin
         top_x_ff   <= pend_x_ff;
         top_y_ff   <= pend_y_ff;
         top_dir_ff <= DIR_NORTH;
      end
      if (cmd.fail && top_dir_ff != DIR_WEST) begin
         top_dir_ff <= top_dir_ff + 2'd1;
      end
      if (cmd.pop_load) begin
         {top_x_ff, top_y_ff, top_dir_ff} <= stack_q;
      end
      if (cmd.emit) begin
         rsp_ev_ff   <= cmd.ev;
         rsp_dir_ff  <= (cmd.ev == EV_STEP || cmd.ev == EV_BACK) ? top_dir_ff : 2'd0;
         rsp_code_ff <= (cmd.ev == EV_FINISH) ? cmd.code : CODE_NOT;
         rsp_last_ff <= (cmd.ev == EV_FINISH);
         if (cmd.ev == EV_START) begin
            rsp_x_ff <= rx_ff;
            rsp_y_ff <= ry_ff;
         end else if (cmd.ev == EV_FINISH) begin
            rsp_x_ff <= walker_x_ff[3:0];
            rsp_y_ff <= walker_y_ff[3:0];
         end else begin
            rsp_x_ff <= 4'd0;
            rsp_y_ff <= 4'd0;
         end
      end
   end

   // Cell RAM word: room flag in bit 0, target flag in bit 1.
   assign sts.kind       = req_tuser;
   assign sts.clr_last   = (clr_cnt_ff == AW'(CELLS - 1));
   assign sts.in_ok      = pend_ok_ff;
   assign sts.exists     = cell_q[0];
   assign sts.target     = cell_q[1];
   assign sts.visited    = vis_q;
   assign sts.dir_last   = (top_dir_ff == DIR_WEST);
   assign sts.depth_one  = (depth_ff == DW'(1));
   assign sts.depth_zero = (depth_ff == '0);
   assign sts.depth_full = (depth_ff >= DW'(CELLS));
   assign sts.rsp_busy   = rsp_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'd0, rsp_code_ff, rsp_y_ff, rsp_x_ff, rsp_dir_ff};

endmodule

@@ rtl/core/gdfts_ctrl.sv @@
// Controller: search phase and the per-request sequencing of the datapath.
module gdfts_ctrl import gdfts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_CLEAR      = 3'd1;
   localparam logic [2:0] ST_START_RD   = 3'd2;
   localparam logic [2:0] ST_START_EVAL = 3'd3;
   localparam logic [2:0] ST_NBR_RD     = 3'd4;
   localparam logic [2:0] ST_NBR_EVAL   = 3'd5;
   localparam logic [2:0] ST_POP_LD     = 3'd6;

   localparam logic [2:0] PH_IDLE         = 3'd0;
   localparam logic [2:0] PH_SEARCH       = 3'd1;
   localparam logic [2:0] PH_CHILD_FAILED = 3'd2;
   localparam logic [2:0] PH_UNWIND       = 3'd3;
   localparam logic [2:0] PH_FIN_FOUND    = 3'd4;
   localparam logic [2:0] PH_FIN_NOT      = 3'd5;
   localparam logic [2:0] PH_FIN_INVALID  = 3'd6;
   localparam logic [2:0] PH_DONE         = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   logic       accept, do_fail, do_path, do_fin;
   logic [1:0] fin_code;

   assign req_tready = (state_ff == ST_IDLE) && !sts.rsp_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      do_fail  = 1'b0;
      do_path  = 1'b0;
      do_fin   = 1'b0;
      fin_code = CODE_NOT;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               case (sts.kind)
                  KIND_LOAD: cmd.load_cell = 1'b1;
                  KIND_START: begin
                     cmd.clr_init = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  KIND_ADVANCE: begin
                     case (phase_ff)
                        PH_FIN_FOUND: begin
                           do_fin = 1'b1;
                           fin_code = CODE_FOUND;
                        end
                        PH_FIN_NOT: do_fin = 1'b1;
                        PH_FIN_INVALID: begin
                           do_fin = 1'b1;
                           fin_code = CODE_INVALID;
                        end
                        PH_UNWIND: begin
                           if (sts.depth_zero) begin
                              do_fin = 1'b1;
                              fin_code = CODE_FOUND;
                           end else begin
                              do_path = 1'b1;
                           end
                        end
                        PH_CHILD_FAILED: begin
                           if (sts.depth_zero) begin
                              do_fin = 1'b1;
                           end else begin
                              do_fail = 1'b1;
                           end
                        end
                        PH_SEARCH: state_in = ST_NBR_RD;
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_START_RD;
            end
         end
         ST_START_RD: begin
            cmd.rd_start = 1'b1;
            state_in = ST_START_EVAL;
         end
         ST_START_EVAL: begin
            cmd.emit = 1'b1;
            cmd.ev   = EV_START;
            state_in = ST_IDLE;
            if (!(sts.in_ok && sts.exists)) begin
               phase_in = PH_FIN_INVALID;
            end else begin
               cmd.enter = 1'b1;
               if (sts.target) begin
                  phase_in = PH_FIN_FOUND;
               end else begin
                  cmd.start_init = 1'b1;
                  phase_in = PH_SEARCH;
               end
            end
         end
         ST_NBR_RD: begin
            if (sts.depth_zero) begin
               do_fin = 1'b1;
            end else begin
               cmd.rd_nbr = 1'b1;
               state_in = ST_NBR_EVAL;
            end
         end
         ST_NBR_EVAL: begin
            if (sts.in_ok && sts.exists && !sts.visited) begin
               cmd.enter = 1'b1;
               if (sts.target) begin
                  do_path = 1'b1;
               end else if (sts.depth_full) begin
                  do_fail = 1'b1;
               end else begin
                  // Descend into the new cell and keep walking within this request.
                  cmd.push = 1'b1;
                  state_in = ST_NBR_RD;
               end
            end else begin
               do_fail = 1'b1;
            end
         end
         ST_POP_LD: begin
            cmd.pop_load = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (do_fin) begin
         cmd.emit = 1'b1;
         cmd.ev   = EV_FINISH;
         cmd.code = fin_code;
         phase_in = PH_DONE;
         state_in = ST_IDLE;
      end
      if (do_path) begin
         cmd.path = 1'b1;
         cmd.emit = 1'b1;
         cmd.ev   = EV_STEP;
         phase_in = sts.depth_one ? PH_FIN_FOUND : PH_UNWIND;
         state_in = sts.depth_one ? ST_IDLE : ST_POP_LD;
      end
      if (do_fail) begin
         cmd.fail = 1'b1;
         cmd.emit = 1'b1;
         cmd.ev   = EV_BACK;
         if (sts.dir_last) begin
            phase_in = sts.depth_one ? PH_FIN_NOT : PH_CHILD_FAILED;
            state_in = sts.depth_one ? ST_IDLE : ST_POP_LD;
         end else begin
            phase_in = PH_SEARCH;
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ rtl/core/grid_depth_first_target_search.sv @@
// A start request first runs a visited-map clearing pass, then reads and checks the start cell.
// Advance: a finish, or a step or backtrack while unwinding, is answered from idle; a search
// step reads then evaluates the map RAMs for the next neighbor, pushes each new cell and
// goes on until a backtrack or path step, with a stack pop load after it when the stack pops.
// One request is in flight at a time; a new request waits until the response is taken.
// Reset is synchronous: controller idles, stack empty, grid size 16 x 16.
module grid_depth_first_target_search import gdfts_pkg::*; #(
   parameter int MAX_WIDTH  = 16,
   parameter int MAX_HEIGHT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // pos_x[3:0], pos_y[7:4], room_exists[8], has_target[9]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // direction[1:0], where_x[5:2], where_y[9:6], found_code[11:10]
   output logic [1:0]  rsp_tuser,  // event_res[1:0]
   output logic        rsp_tlast,  // done_res
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [4:0]  csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   gdfts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gdfts_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_ready_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request taken while a response is pending");

   a_last_is_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == EV_FINISH)))
      else $error("done flag does not match finish event");

   a_code_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != EV_FINISH) |-> (rsp_tdata[11:10] == CODE_NOT))
      else $error("found code set on a non-finish event");

   a_start_answers_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == KIND_START) |=> !req_tready)
      else $error("start request did not hold off the next request");

endmodule
